>>> sv/csem_pkg.sv
// shared types, codes and sizes for the counting semaphore wait list
package csem_pkg;

    // wait list sizing
    localparam int MAX_WAITERS = 16;
    localparam int WAIT_AW     = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int WAIT_TW     = $clog2(MAX_WAITERS + 1);

    // queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    // configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int INIT_W      = 15;
    localparam logic [PADDR_W-1:0] ADDR_INIT_COUNT = 3'd0;

    // semaphore count
    localparam int CNT_W = 16;
    localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sd32767;

    // request function codes
    localparam logic [1:0] FUNC_WAIT   = 2'd0;
    localparam logic [1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [1:0] FUNC_CLOSE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_CLOSED  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // decoded operation
    typedef enum logic [1:0] {
        OP_WAIT,
        OP_SIGNAL,
        OP_CLOSE,
        OP_BAD
    } op_t;

    // input beat
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] thread_id;
    } in_beat_t;

    // output beat
    typedef struct packed {
        logic [1:0] status;
        logic       released_valid;
        logic [7:0] released_thread;
        logic       released_by_close;
        logic       last;
    } out_beat_t;

    // classified request held in the queue
    typedef struct packed {
        op_t        op;
        logic [7:0] thread_id;
    } q_entry_t;

    // open command from the configuration port
    typedef struct packed {
        logic              open;
        logic [INIT_W-1:0] init_count;
    } open_cmd_t;

endpackage

>>> sv/csem_front.sv
// front stage: takes request beats and classifies the function code
module csem_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  csem_pkg::in_beat_t in_data,
    output logic               push_valid,
    output csem_pkg::q_entry_t push_entry,
    input  logic               q_full
);
    import csem_pkg::*;

    logic     front_valid_reg;
    logic     front_valid_next;
    q_entry_t front_entry_reg;
    q_entry_t front_entry_next;
    logic     accept;
    op_t      op_dec;

    // function code decode
    always_comb
    begin
        unique case (in_data.func)
            FUNC_WAIT:   op_dec = OP_WAIT;
            FUNC_SIGNAL: op_dec = OP_SIGNAL;
            FUNC_CLOSE:  op_dec = OP_CLOSE;
            default:     op_dec = OP_BAD;
        endcase
    end

    // hold while the queue is full
    assign in_stall = front_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        front_valid_next = accept || (front_valid_reg && q_full);
        front_entry_next = front_entry_reg;
        if (accept)
        begin
            front_entry_next.op        = op_dec;
            front_entry_next.thread_id = in_data.thread_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        front_entry_reg <= front_entry_next;
    end

    assign push_valid = front_valid_reg && !q_full;
    assign push_entry = front_entry_reg;

endmodule

>>> sv/csem_queue.sv
// short request queue between the front and back stages
module csem_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  csem_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output csem_pkg::q_entry_t pop_entry
);
    import csem_pkg::*;

    q_entry_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_next;
    logic [QUEUE_AW:0]       fill_reg;
    logic [QUEUE_AW:0]       fill_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_entry = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> sv/csem_back.sv
// back stage: semaphore count, wait stack and result beats
module csem_back (
    input  logic                clk,
    input  logic                rst_n,
    input  csem_pkg::open_cmd_t open_cmd,
    input  logic                q_valid,
    input  csem_pkg::q_entry_t  q_entry,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output csem_pkg::out_beat_t out_data
);
    import csem_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GAP,
        S_DRAIN
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    op_t                      op_reg;
    op_t                      op_next;
    logic [7:0]               tid_reg;
    logic [7:0]               tid_next;
    logic signed [CNT_W-1:0]  cnt_reg;
    logic signed [CNT_W-1:0]  cnt_next;
    logic signed [CNT_W-1:0]  cnt_inc;
    logic                     closed_reg;
    logic                     closed_next;
    logic [WAIT_TW-1:0]       total_reg;
    logic [WAIT_TW-1:0]       total_next;
    logic [WAIT_TW-1:0]       total_m1;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_beat_t                out_data_reg;
    out_beat_t                out_data_next;

    // wait stack memory
    logic [7:0]               stack_mem [MAX_WAITERS];
    logic [7:0]               rd_data_reg;
    logic                     push_en;
    logic                     out_free;
    logic                     list_full;

    assign total_m1  = total_reg - 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign list_full = (total_reg >= WAIT_TW'(MAX_WAITERS));
    assign cnt_inc   = (cnt_reg < COUNT_MAX) ? cnt_reg + 16'sd1 : cnt_reg;

    // top of stack read every cycle, push at the fill level
    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[total_m1[WAIT_AW-1:0]];
        if (push_en)
            stack_mem[total_reg[WAIT_AW-1:0]] <= tid_reg;
    end

    // request execution and close drain
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        cnt_next       = cnt_reg;
        closed_next    = closed_reg;
        total_next     = total_reg;
        push_en        = 1'b0;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_entry.op;
                    tid_next   = q_entry.thread_id;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.last = 1'b1;
                    state_next     = S_IDLE;
                    unique case (op_reg)
                        OP_WAIT:
                        begin
                            if (closed_reg)
                                out_data_next.status = ST_CLOSED;
                            else if (cnt_reg <= 16'sd0)
                            begin
                                if (list_full)
                                    out_data_next.status = ST_FULL;
                                else
                                begin
                                    push_en    = 1'b1;
                                    total_next = total_reg + 1'b1;
                                    cnt_next   = cnt_reg - 16'sd1;
                                    out_data_next.status = ST_BLOCKED;
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 16'sd1;
                                out_data_next.status = ST_OK;
                            end
                        end
                        OP_SIGNAL:
                        begin
                            if (closed_reg)
                                out_data_next.status = ST_CLOSED;
                            else
                            begin
                                cnt_next = cnt_inc;
                                out_data_next.status = ST_OK;
                                if (cnt_inc <= 16'sd0 && total_reg != '0)
                                begin
                                    total_next = total_m1;
                                    out_data_next.released_valid  = 1'b1;
                                    out_data_next.released_thread = rd_data_reg;
                                end
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (closed_reg)
                                out_data_next.status = ST_CLOSED;
                            else
                            begin
                                closed_next = 1'b1;
                                out_data_next.status = ST_OK;
                                if (total_reg != '0)
                                begin
                                    total_next = total_m1;
                                    out_data_next.released_valid    = 1'b1;
                                    out_data_next.released_thread   = rd_data_reg;
                                    out_data_next.released_by_close = 1'b1;
                                    out_data_next.last = (total_m1 == '0);
                                    if (total_m1 != '0)
                                        state_next = S_GAP;
                                end
                            end
                        end
                        default:
                        begin
                            out_data_next.status = ST_CLOSED;
                        end
                    endcase
                end
            end
            S_GAP:
            begin
                // let the stack read catch up with the new top
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.status            = ST_OK;
                    out_data_next.released_valid    = 1'b1;
                    out_data_next.released_thread   = rd_data_reg;
                    out_data_next.released_by_close = 1'b1;
                    out_data_next.last              = (total_m1 == '0);
                    total_next = total_m1;
                    state_next = (total_m1 == '0) ? S_IDLE : S_GAP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // open from the configuration port; the user must write it only while idle, the block does not enforce this
        if (open_cmd.open)
        begin
            cnt_next    = $signed({1'b0, open_cmd.init_count});
            closed_next = 1'b0;
            total_next  = '0;
            state_next  = S_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_WAIT;
            tid_reg       <= '0;
            cnt_reg       <= '0;
            closed_reg    <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            tid_reg       <= tid_next;
            cnt_reg       <= cnt_next;
            closed_reg    <= closed_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/counting_semaphore_wait_list.sv
// top level of the counting semaphore with its wait list
//
//   channel   direction   handshake           beat
//   in        input       in_valid/in_stall   in_beat_t: func, thread_id
//   out       output      out_valid/out_stall out_beat_t: status, release, last
//   apb       input       psel/penable/pready init_count at byte address 0
//
// wait and signal pass through the back stage in S_IDLE, which pops the queue while
// the stack top is read, and S_EXEC, which updates the count and loads the output register.
// close releases the waiters one at a time, passing S_GAP before each later release for the stack read.
// reset and an init_count write reopen the semaphore: count loaded, list empty.
// a stalled output holds the back stage; the front keeps taking beats until the
// two-entry queue fills and the front register holds a beat.
module counting_semaphore_wait_list (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csem_pkg::PADDR_W-1:0]      paddr,
    input  logic [csem_pkg::PDATA_W-1:0]      pwdata,
    output logic [csem_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  csem_pkg::in_beat_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output csem_pkg::out_beat_t               out_data
);
    import csem_pkg::*;

    logic [INIT_W-1:0] init_count_reg;
    logic [INIT_W-1:0] init_count_next;
    logic              init_wr;
    open_cmd_t         open_cmd;
    logic              push_valid;
    q_entry_t          push_entry;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    q_entry_t          q_entry;

    // register write and read-back
    assign pready  = 1'b1;
    assign init_wr = psel && penable && pwrite && (paddr == ADDR_INIT_COUNT);
    assign init_count_next = init_wr ? pwdata[INIT_W-1:0] : init_count_reg;
    assign prdata  = (paddr == ADDR_INIT_COUNT) ?
                     {{(PDATA_W-INIT_W){1'b0}}, init_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_count_reg <= '0;
        else
            init_count_reg <= init_count_next;
    end

    assign open_cmd.open       = init_wr;
    assign open_cmd.init_count = pwdata[INIT_W-1:0];

    csem_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    csem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    csem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .open_cmd  (open_cmd),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> tb/counting_semaphore_wait_list_test.sv
// self-checking testbench for the counting semaphore wait list
`timescale 1ns / 100ps

import csem_pkg::*;

class semaphore_scoreboard;
    out_beat_t               pending_results[$];
    int                      failures;
    logic signed [CNT_W-1:0] sem_value;
    bit                      sem_closed;
    logic [7:0]              parked_ids[MAX_WAITERS];
    int                      parked_total;

    function new();
        failures = 0;
        reopen('0);
    endfunction

    // an init_count write reopens the semaphore
    function void reopen(logic [INIT_W-1:0] init);
        sem_value    = $signed({1'b0, init});
        sem_closed   = 1'b0;
        parked_total = 0;
    endfunction

    function void push_result(logic [1:0] status, logic rel_valid, logic [7:0] rel_id,
                              logic by_close, logic is_last);
        out_beat_t r;
        r.status            = status;
        r.released_valid    = rel_valid;
        r.released_thread   = rel_id;
        r.released_by_close = by_close;
        r.last              = is_last;
        pending_results.push_back(r);
    endfunction

    // update the semaphore for an accepted request beat and queue its results
    function void note_request(in_beat_t req);
        case (req.func)
            FUNC_WAIT:
            begin
                if (sem_closed)
                    push_result(ST_CLOSED, 1'b0, 8'd0, 1'b0, 1'b1);
                else if (sem_value <= 0)
                begin
                    if (parked_total >= MAX_WAITERS)
                        push_result(ST_FULL, 1'b0, 8'd0, 1'b0, 1'b1);
                    else
                    begin
                        parked_ids[parked_total] = req.thread_id;
                        parked_total++;
                        sem_value = sem_value - 16'sd1;
                        push_result(ST_BLOCKED, 1'b0, 8'd0, 1'b0, 1'b1);
                    end
                end
                else
                begin
                    sem_value = sem_value - 16'sd1;
                    push_result(ST_OK, 1'b0, 8'd0, 1'b0, 1'b1);
                end
            end
            FUNC_SIGNAL:
            begin
                if (sem_closed)
                    push_result(ST_CLOSED, 1'b0, 8'd0, 1'b0, 1'b1);
                else
                begin
                    // count saturates at the top
                    if (sem_value < COUNT_MAX)
                        sem_value = sem_value + 16'sd1;
                    if (sem_value <= 0 && parked_total > 0)
                    begin
                        parked_total--;
                        push_result(ST_OK, 1'b1, parked_ids[parked_total], 1'b0, 1'b1);
                    end
                    else
                        push_result(ST_OK, 1'b0, 8'd0, 1'b0, 1'b1);
                end
            end
            FUNC_CLOSE:
            begin
                if (sem_closed)
                    push_result(ST_CLOSED, 1'b0, 8'd0, 1'b0, 1'b1);
                else
                begin
                    sem_closed = 1'b1;
                    if (parked_total == 0)
                        push_result(ST_OK, 1'b0, 8'd0, 1'b0, 1'b1);
                    // release every waiter, newest first
                    while (parked_total > 0)
                    begin
                        parked_total--;
                        push_result(ST_OK, 1'b1, parked_ids[parked_total], 1'b1,
                                    parked_total == 0);
                    end
                end
            end
            default:
                push_result(ST_CLOSED, 1'b0, 8'd0, 1'b0, 1'b1);
        endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // compare a result beat with the oldest expectation
    function void check_result(out_beat_t got);
        out_beat_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat with nothing expected: %p", got);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", 8'(want.status), 8'(got.status));
        compare_field("released_valid", 8'(want.released_valid), 8'(got.released_valid));
        compare_field("released_thread", want.released_thread, got.released_thread);
        compare_field("released_by_close", 8'(want.released_by_close),
                      8'(got.released_by_close));
        compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
endclass

module counting_semaphore_wait_list_test;

    localparam int          CLK_PERIOD      = 4;
    localparam int          RESET_CYCLES    = 7;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          PHASE_ITEMS     = 28;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam logic [1:0]  FUNC_UNUSED     = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    in_beat_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_beat_t          out_data;

    semaphore_scoreboard sb;
    int                  send_idle_pct;
    int                  stall_pct;
    bit                  hold_off_pending;
    int unsigned         cycle_count = 0;

    counting_semaphore_wait_list uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("counting_semaphore_wait_list_test NOT OK");
            $finish;
        end
    end

    // watch both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic in_beat_t make_request(logic [1:0] func, logic [7:0] id);
        in_beat_t r;
        r.func      = func;
        r.thread_id = id;
        return r;
    endfunction

    // mostly waits and signals, a few closes and unused codes
    function automatic in_beat_t random_request();
        int         pick;
        logic [1:0] func;
        pick = $urandom_range(99);
        if (pick < 55)
            func = FUNC_WAIT;
        else if (pick < 95)
            func = FUNC_SIGNAL;
        else if (pick < 96)
            func = FUNC_CLOSE;
        else
            func = FUNC_UNUSED;
        return make_request(func, 8'($urandom_range(255)));
    endfunction

    // offer one beat after a random gap and hold it until taken
    task automatic send_request(input in_beat_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // apb write with setup and access cycles
    task automatic write_init_count(input logic [INIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_INIT_COUNT;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.reopen(value);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int               i;
        int               phase;
        logic [INIT_W-1:0] init;

        sb               = new();
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_off_pending = 1'b0;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        in_data          = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: block, release, fill the list, overflow, close, closed errors
        write_init_count('0);
        send_request(make_request(FUNC_WAIT, 8'h00));
        send_request(make_request(FUNC_SIGNAL, 8'hFF));
        send_request(make_request(FUNC_UNUSED, 8'h5A));
        for (i = 0; i < MAX_WAITERS; i++)
            send_request(make_request(FUNC_WAIT, (i == 0) ? 8'hFF : 8'(i * 17)));
        send_request(make_request(FUNC_WAIT, 8'h3C));
        send_request(make_request(FUNC_CLOSE, 8'h81));
        send_request(make_request(FUNC_CLOSE, 8'h7E));
        send_request(make_request(FUNC_WAIT, 8'hC3));
        send_request(make_request(FUNC_SIGNAL, 8'h24));
        in_valid <= 1'b0;
        wait_drained();

        // random phases over the idling modes and several initial counts
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 83; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 8;  stall_pct = 8;  end
            endcase
            case (phase)
                0:       init = 15'h7FFF;
                1:       init = '0;
                2:       init = INIT_W'($urandom_range(3, 1));
                3:       init = '0;
                4:       init = INIT_W'($urandom_range(32767));
                default: init = INIT_W'($urandom_range(2));
            endcase
            write_init_count(init);

            // signal at the saturation point
            if (phase == 0)
                send_request(make_request(FUNC_SIGNAL, 8'h99));

            // long receiver hold-off so the block fills and stalls its input
            if (phase == 3)
                hold_off_pending = 1'b1;

            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(random_request());
            if ($urandom_range(1) == 1)
                send_request(make_request(FUNC_CLOSE, 8'($urandom_range(255))));
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("counting_semaphore_wait_list_test OK");
        else
            $display("counting_semaphore_wait_list_test NOT OK");
        $finish;
    end

endmodule
